// ----- rtl/hlt_pkg.sv -----
// shared types and constants for the heartbeat liveness table
`default_nettype none

package hlt_pkg;

    localparam int MAX_ENTRIES = 8;
    localparam int SLOT_W      = 3;
    localparam int CNT_W       = 4;
    localparam int ID_W        = 32;
    localparam int TIME_W      = 32;
    localparam int THR_W       = 16;

    localparam logic [1:0] CMD_STATUS = 2'd0;
    localparam logic [1:0] CMD_TICK   = 2'd1;
    localparam logic [1:0] CMD_SWEEP  = 2'd2;

    localparam logic [7:0] OFFLINE_STATUS = 8'd6;

    localparam logic [2:0] EV_REFRESHED = 3'd0;
    localparam logic [2:0] EV_OFFLINE   = 3'd1;
    localparam logic [2:0] EV_ADDED     = 3'd2;
    localparam logic [2:0] EV_DROPPED   = 3'd3;
    localparam logic [2:0] EV_STALE     = 3'd4;
    localparam logic [2:0] EV_SWEEP     = 3'd5;
    localparam logic [2:0] EV_TICK      = 3'd6;

    localparam logic [THR_W-1:0] THR_RESET = 16'd35;

    typedef enum logic {
        ST_IDLE,
        ST_SWEEP
    } t_state;

    // controls shared by every cell
    typedef struct packed {
        logic              lookup;
        logic              offline;
        logic [ID_W-1:0]   client_id;
        logic [TIME_W-1:0] now;
    } t_cell_cmd;

    // controls for one cell
    typedef struct packed {
        logic valid;
        logic append_here;
        logic sweep_drop_here;
    } t_cell_sel;

endpackage

`default_nettype wire

// ----- rtl/hlt_cell.sv -----
// one table entry: id and last-heard time, with search and shift chains
`default_nettype none

module hlt_cell import hlt_pkg::*; (
    input  wire logic              i_clk,
    input  wire t_cell_cmd         i_cmd,
    input  wire t_cell_sel         i_sel,
    input  wire logic              i_found,
    output logic                   o_found,
    input  wire logic              i_shift,
    output logic                   o_shift,
    input  wire logic [ID_W-1:0]   i_next_id,
    input  wire logic [TIME_W-1:0] i_next_time,
    output logic [ID_W-1:0]        o_id,
    output logic [TIME_W-1:0]      o_time,
    output logic                   o_hit
);

    logic [ID_W-1:0]   r_id;
    logic [TIME_W-1:0] r_time;
    logic              s_match;
    logic              s_drop;

    assign s_match = i_sel.valid && (r_id == i_cmd.client_id);
    assign o_hit   = i_cmd.lookup && s_match && !i_found;
    assign o_found = i_found || s_match;
    assign s_drop  = (o_hit && i_cmd.offline) || i_sel.sweep_drop_here;
    // every cell at or after the removal point takes its neighbor's entry
    assign o_shift = i_shift || s_drop;
    assign o_id    = r_id;
    assign o_time  = r_time;

    always_ff @(posedge i_clk) begin
        if (o_shift) begin
            r_id   <= i_next_id;
            r_time <= i_next_time;
        end else if (i_sel.append_here) begin
            r_id   <= i_cmd.client_id;
            r_time <= i_cmd.now;
        end else if (o_hit) begin
            r_time <= i_cmd.now;
        end
    end

endmodule

`default_nettype wire

// ----- rtl/heartbeat_liveness_table_top.sv -----
// heartbeat liveness table: top level with control, counters and result register
//
// Requests enter on i_in_valid / o_in_stall with i_command, i_client_id and
// i_status_code; results leave on o_out_valid / i_out_stall, one per cycle
// while the receiver does not stall. A status request or a tick gives one
// result, registered in the cycle after the request is taken; with the
// output free a new request is taken every cycle. A sweep walks the table
// one entry per cycle while the output is free: an entry that is stale
// gives a removal result, a fresh one just advances, and a final sweep-done
// result closes it; the input stays stalled until the sweep is done.
// Command 3 is taken and dropped without a result.
// When the receiver stalls, the result register holds its payload and the
// block stops: no request is taken and the sweep pauses until the result
// moves on. Reset empties the table, zeroes the tick counter and sets the
// threshold to 35; the entry storage itself is not cleared.
// The threshold register sits at address 0 of the APB port; it is meant to
// be written while the block is idle.
`default_nettype none

module heartbeat_liveness_table_top import hlt_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_stall,
    input  wire logic [1:0]        i_command,
    input  wire logic [ID_W-1:0]   i_client_id,
    input  wire logic [7:0]        i_status_code,
    output logic                   o_out_valid,
    input  wire logic              i_out_stall,
    output logic [2:0]             o_event_res,
    output logic [SLOT_W-1:0]      o_slot,
    output logic [ID_W-1:0]        o_client_of_event,
    output logic [CNT_W-1:0]       o_live_count,
    output logic                   o_shutdown,
    output logic                   o_last,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [2:0]        paddr,
    input  wire logic [31:0]       pwdata,
    output logic [31:0]            prdata,
    output logic                   pready
);

    t_state            r_state, n_state;
    logic [CNT_W-1:0]  r_count, n_count;
    logic [TIME_W-1:0] r_now, n_now;
    logic [THR_W-1:0]  r_thr;
    logic [CNT_W-1:0]  r_idx, n_idx;
    logic              r_removed, n_removed;

    logic              r_out_valid;
    logic [2:0]        r_ev, n_ev;
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [ID_W-1:0]   r_cid, n_cid;
    logic [CNT_W-1:0]  r_live, n_live;
    logic              r_sd, n_sd;
    logic              r_last, n_last;
    logic              n_load;

    logic              s_in_accept;
    logic              s_out_free;
    logic              s_found;
    logic [SLOT_W-1:0] s_hit_pos;
    logic              s_in_range;
    logic              s_stale;
    logic [TIME_W-1:0] s_age;

    t_cell_cmd         s_cmd;
    t_cell_sel         s_sel   [MAX_ENTRIES];
    logic [MAX_ENTRIES-1:0] s_append;
    logic [MAX_ENTRIES-1:0] s_sweep_drop;

    logic              w_found [MAX_ENTRIES+1];
    logic              w_shift [MAX_ENTRIES+1];
    logic [ID_W-1:0]   w_id    [MAX_ENTRIES+1];
    logic [TIME_W-1:0] w_time  [MAX_ENTRIES+1];
    logic [MAX_ENTRIES-1:0] w_hit;

    assign s_out_free  = !r_out_valid || !i_out_stall;
    assign o_in_stall  = (r_state != ST_IDLE) || !s_out_free;
    assign s_in_accept = i_in_valid && !o_in_stall;

    assign s_cmd.lookup    = s_in_accept && (i_command == CMD_STATUS);
    assign s_cmd.offline   = (i_status_code == OFFLINE_STATUS);
    assign s_cmd.client_id = i_client_id;
    assign s_cmd.now       = r_now;

    assign w_found[0]           = 1'b0;
    assign w_shift[0]           = 1'b0;
    assign w_id[MAX_ENTRIES]    = '0;
    assign w_time[MAX_ENTRIES]  = '0;

    for (genvar g = 0; g < MAX_ENTRIES; g++) begin : g_cell
        assign s_sel[g].valid           = (CNT_W'(g) < r_count);
        assign s_sel[g].append_here     = s_append[g];
        assign s_sel[g].sweep_drop_here = s_sweep_drop[g];

        hlt_cell u_cell (
            .i_clk       (i_clk),
            .i_cmd       (s_cmd),
            .i_sel       (s_sel[g]),
            .i_found     (w_found[g]),
            .o_found     (w_found[g+1]),
            .i_shift     (w_shift[g]),
            .o_shift     (w_shift[g+1]),
            .i_next_id   (w_id[g+1]),
            .i_next_time (w_time[g+1]),
            .o_id        (w_id[g]),
            .o_time      (w_time[g]),
            .o_hit       (w_hit[g])
        );
    end

    assign s_found = s_cmd.lookup && w_found[MAX_ENTRIES];

    always_comb begin
        s_hit_pos = '0;
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            if (w_hit[i]) begin
                s_hit_pos = s_hit_pos | SLOT_W'(i);
            end
        end
    end

    always_comb begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
            s_append[i] = s_cmd.lookup && !s_found && (r_count == CNT_W'(i));
        end
    end

    // sweep examines the entry at the walk pointer
    assign s_in_range = (r_idx < r_count);
    assign s_age      = r_now - w_time[r_idx];
    assign s_stale    = s_age > {{(TIME_W-THR_W){1'b0}}, r_thr};

    always_comb begin
        n_state = r_state;
        case (r_state)
            ST_IDLE: begin
                if (s_in_accept && (i_command == CMD_SWEEP)) begin
                    n_state = ST_SWEEP;
                end
            end
            ST_SWEEP: begin
                if (s_out_free && !s_in_range) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        n_count      = r_count;
        n_now        = r_now;
        n_idx        = r_idx;
        n_removed    = r_removed;
        n_load       = 1'b0;
        n_ev         = EV_REFRESHED;
        n_slot       = '0;
        n_cid        = '0;
        n_live       = r_count;
        n_sd         = 1'b0;
        n_last       = 1'b1;
        s_sweep_drop = '0;
        case (r_state)
            ST_IDLE: begin
                if (s_in_accept) begin
                    case (i_command)
                        CMD_STATUS: begin
                            n_load = 1'b1;
                            n_cid  = i_client_id;
                            if (s_found) begin
                                n_slot = s_hit_pos;
                                if (s_cmd.offline) begin
                                    n_ev    = EV_OFFLINE;
                                    n_count = r_count - CNT_W'(1);
                                end else begin
                                    n_ev = EV_REFRESHED;
                                end
                            end else if (r_count < CNT_W'(MAX_ENTRIES)) begin
                                n_ev    = EV_ADDED;
                                n_slot  = r_count[SLOT_W-1:0];
                                n_count = r_count + CNT_W'(1);
                            end else begin
                                n_ev = EV_DROPPED;
                            end
                            n_live = n_count;
                        end
                        CMD_TICK: begin
                            n_load = 1'b1;
                            n_ev   = EV_TICK;
                            n_now  = r_now + TIME_W'(1);
                        end
                        CMD_SWEEP: begin
                            n_idx     = '0;
                            n_removed = 1'b0;
                        end
                        default: ;
                    endcase
                end
            end
            ST_SWEEP: begin
                if (s_out_free) begin
                    if (s_in_range) begin
                        if (s_stale) begin
                            s_sweep_drop[r_idx[SLOT_W-1:0]] = 1'b1;
                            n_load    = 1'b1;
                            n_ev      = EV_STALE;
                            n_slot    = r_idx[SLOT_W-1:0];
                            n_cid     = w_id[r_idx];
                            n_count   = r_count - CNT_W'(1);
                            n_live    = n_count;
                            n_last    = 1'b0;
                            n_removed = 1'b1;
                        end else begin
                            n_idx = r_idx + CNT_W'(1);
                        end
                    end else begin
                        n_load = 1'b1;
                        n_ev   = EV_SWEEP;
                        n_sd   = r_removed && (r_count == '0);
                    end
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_count     <= '0;
            r_now       <= '0;
            r_thr       <= THR_RESET;
            r_idx       <= '0;
            r_removed   <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_count   <= n_count;
            r_now     <= n_now;
            r_idx     <= n_idx;
            r_removed <= n_removed;
            if (psel && penable && pwrite && !paddr[2]) begin
                r_thr <= pwdata[THR_W-1:0];
            end
            if (n_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (n_load) begin
            r_ev   <= n_ev;
            r_slot <= n_slot;
            r_cid  <= n_cid;
            r_live <= n_live;
            r_sd   <= n_sd;
            r_last <= n_last;
        end
    end

    assign o_out_valid       = r_out_valid;
    assign o_event_res       = r_ev;
    assign o_slot            = r_slot;
    assign o_client_of_event = r_cid;
    assign o_live_count      = r_live;
    assign o_shutdown        = r_sd;
    assign o_last            = r_last;

    assign pready = 1'b1;
    assign prdata = paddr[2] ? 32'd0 : {{(32-THR_W){1'b0}}, r_thr};

endmodule

`default_nettype wire
